// ----- src/srb_pkg.sv -----
// ----------------------------------------------------------------------------
// srb_pkg: shared definitions for the serial receive buffer
// Buffer depth, pointer and count widths, request codes, sequencer states,
// the result record and pointer arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

	// Buffer geometry (depth may range from 2 to 128)
	localparam int DEPTH = 64;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	// Request codes carried in the mode field
	typedef enum logic [2:0] {
		MODE_RECV       = 3'd0,
		MODE_READ_ONE   = 3'd1,
		MODE_READ_COUNT = 3'd2,
		MODE_READ_TERM  = 3'd3,
		MODE_CLEAR      = 3'd4
	} mode_t;

	// Kind of request parked until enough bytes or its terminator arrive
	typedef enum logic [1:0] {
		WAIT_NONE  = 2'd0,
		WAIT_COUNT = 2'd1,
		WAIT_TERM  = 2'd2
	} wait_kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMPTY_OUT
	} state_t;

	// One result record
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       empty_read;
		logic [6:0] bytes_held;
	} res_t;

	localparam logic [7:0] EMPTY_BYTE = 8'hFF;

	// Ring pointer advance by one
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Ring pointer plus offset, both below DEPTH
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
			input logic [PTR_W-1:0] b);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/srb_if.sv -----
// ----------------------------------------------------------------------------
// srb_if: request and result channels of the serial receive buffer
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface srb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] data_byte;
	logic [7:0] request_len;
	logic [7:0] terminator;

	modport source (output valid, mode, data_byte, request_len, terminator, input ready);
	modport sink (input valid, mode, data_byte, request_len, terminator, output ready);
endinterface

interface srb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       empty_read;
	logic [6:0] bytes_held;

	modport source (output valid, out_byte, last_of_run, empty_read, bytes_held, input ready);
	modport sink (input valid, out_byte, last_of_run, empty_read, bytes_held, output ready);
endinterface

`default_nettype wire

// ----- src/srb_seq.sv -----
// ----------------------------------------------------------------------------
// srb_seq: byte ring, pointers and request sequencer
// Holds the byte memory and walks it one entry per step with a single
// compare unit for terminator scans and run emission.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_seq (
	input  wire logic         clk,
	input  wire logic         arst_n,
	srb_req_if.sink           req,
	output logic              res_valid,
	output srb_pkg::res_t     res,
	input  wire logic         res_ready
);

	srb_pkg::state_t     state_q, state_d;
	srb_pkg::wait_kind_t kind_q;

	logic [srb_pkg::PTR_W-1:0] head_q, tail_q, idx_q, rd_addr;
	logic [srb_pkg::CNT_W-1:0] count_q, run_q;
	logic [7:0]                wlen_q, wterm_q;

	logic [7:0] mem [srb_pkg::DEPTH];
	logic [7:0] rdata_q;

	logic                      accept, full, rel_count, rel_term, scan_hit, scan_end;
	logic [srb_pkg::CNT_W-1:0] cnt_new, len_sat, rel_len, count_inc;
	logic [7:0]                len1;

	// Request decode helpers
	assign req.ready = (state_q == srb_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == srb_pkg::CNT_W'(srb_pkg::DEPTH));
	assign count_inc = count_q + srb_pkg::CNT_W'(1);
	assign cnt_new   = full ? count_q : count_inc;
	assign len_sat   = (req.request_len > 8'(srb_pkg::DEPTH)) ?
		srb_pkg::CNT_W'(srb_pkg::DEPTH) : srb_pkg::CNT_W'(req.request_len);
	assign len1      = (req.request_len == 8'd0) ? 8'd1 : req.request_len;

	// Release checks for a parked request on byte arrival
	assign rel_count = (kind_q == srb_pkg::WAIT_COUNT) && (8'(cnt_new) >= wlen_q);
	assign rel_term  = (kind_q == srb_pkg::WAIT_TERM) && (req.data_byte == wterm_q);
	assign rel_len   = (8'(cnt_new) < wlen_q) ? cnt_new : srb_pkg::CNT_W'(wlen_q);

	// Shared compare unit for the scan
	assign scan_hit = (rdata_q == wterm_q) || ((8'(idx_q) + 8'd1) == wlen_q);
	assign scan_end = ((srb_pkg::CNT_W'(idx_q) + srb_pkg::CNT_W'(1)) == count_q);

	// Read address: scan offset or head
	always_comb begin
		rd_addr = head_q;
		if (state_q == srb_pkg::ST_SCAN_RD) begin
			rd_addr = srb_pkg::ptr_add(head_q, idx_q);
		end
	end

	// Byte memory, registered read
	always_ff @(posedge clk) begin
		if (accept && req.mode == srb_pkg::MODE_RECV) begin
			mem[tail_q] <= req.data_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srb_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.mode == srb_pkg::MODE_RECV) begin
						if (rel_count || rel_term) begin
							state_d = srb_pkg::ST_EMIT_RD;
						end
					end else if (kind_q == srb_pkg::WAIT_NONE) begin
						case (req.mode)
							srb_pkg::MODE_READ_ONE: begin
								state_d = (count_q == '0) ? srb_pkg::ST_EMPTY_OUT :
									srb_pkg::ST_EMIT_RD;
							end
							srb_pkg::MODE_READ_COUNT: begin
								if (count_q >= len_sat && len_sat != '0) begin
									state_d = srb_pkg::ST_EMIT_RD;
								end
							end
							srb_pkg::MODE_READ_TERM: begin
								if (count_q != '0) begin
									state_d = srb_pkg::ST_SCAN_RD;
								end
							end
							default: state_d = srb_pkg::ST_IDLE;
						endcase
					end
				end
			end
			srb_pkg::ST_SCAN_RD: state_d = srb_pkg::ST_SCAN_CMP;
			srb_pkg::ST_SCAN_CMP: begin
				if (scan_hit) begin
					state_d = srb_pkg::ST_EMIT_RD;
				end else if (scan_end) begin
					state_d = srb_pkg::ST_IDLE;
				end else begin
					state_d = srb_pkg::ST_SCAN_RD;
				end
			end
			srb_pkg::ST_EMIT_RD: state_d = srb_pkg::ST_EMIT_OUT;
			srb_pkg::ST_EMIT_OUT: begin
				if (res_ready) begin
					state_d = (run_q == srb_pkg::CNT_W'(1)) ? srb_pkg::ST_IDLE :
						srb_pkg::ST_EMIT_RD;
				end
			end
			srb_pkg::ST_EMPTY_OUT: begin
				if (res_ready) begin
					state_d = srb_pkg::ST_IDLE;
				end
			end
			default: state_d = srb_pkg::ST_IDLE;
		endcase
	end

	// Result outputs
	always_comb begin
		res_valid       = 1'b0;
		res.out_byte    = rdata_q;
		res.last_of_run = (run_q == srb_pkg::CNT_W'(1));
		res.empty_read  = 1'b0;
		res.bytes_held  = 7'(count_q - srb_pkg::CNT_W'(1));
		unique case (state_q)
			srb_pkg::ST_EMIT_OUT: res_valid = 1'b1;
			srb_pkg::ST_EMPTY_OUT: begin
				res_valid       = 1'b1;
				res.out_byte    = srb_pkg::EMPTY_BYTE;
				res.last_of_run = 1'b1;
				res.empty_read  = 1'b1;
				res.bytes_held  = 7'(count_q);
			end
			default: res_valid = 1'b0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pointers, count, parked request and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			kind_q  <= srb_pkg::WAIT_NONE;
			wlen_q  <= '0;
			wterm_q <= '0;
			idx_q   <= '0;
			run_q   <= '0;
		end else begin
			unique case (state_q)
				srb_pkg::ST_IDLE: begin
					if (accept) begin
						if (req.mode == srb_pkg::MODE_RECV) begin
							tail_q  <= srb_pkg::ptr_inc(tail_q);
							count_q <= cnt_new;
							if (full) begin
								head_q <= srb_pkg::ptr_inc(head_q);
							end
							if (rel_count) begin
								kind_q <= srb_pkg::WAIT_NONE;
								run_q  <= srb_pkg::CNT_W'(wlen_q);
							end else if (rel_term) begin
								kind_q <= srb_pkg::WAIT_NONE;
								run_q  <= rel_len;
							end
						end else if (kind_q == srb_pkg::WAIT_NONE) begin
							case (req.mode)
								srb_pkg::MODE_READ_ONE: run_q <= srb_pkg::CNT_W'(1);
								srb_pkg::MODE_READ_COUNT: begin
									if (count_q >= len_sat) begin
										run_q <= len_sat;
									end else begin
										kind_q <= srb_pkg::WAIT_COUNT;
										wlen_q <= 8'(len_sat);
									end
								end
								srb_pkg::MODE_READ_TERM: begin
									wlen_q  <= len1;
									wterm_q <= req.terminator;
									idx_q   <= '0;
									if (count_q == '0) begin
										kind_q <= srb_pkg::WAIT_TERM;
									end
								end
								srb_pkg::MODE_CLEAR: begin
									head_q  <= '0;
									tail_q  <= '0;
									count_q <= '0;
								end
								default: run_q <= run_q;
							endcase
						end
					end
				end
				srb_pkg::ST_SCAN_CMP: begin
					if (scan_hit) begin
						run_q <= srb_pkg::CNT_W'(idx_q) + srb_pkg::CNT_W'(1);
					end else if (scan_end) begin
						kind_q <= srb_pkg::WAIT_TERM;
					end else begin
						idx_q <= idx_q + srb_pkg::PTR_W'(1);
					end
				end
				srb_pkg::ST_EMIT_OUT: begin
					if (res_ready) begin
						head_q  <= srb_pkg::ptr_inc(head_q);
						count_q <= count_q - srb_pkg::CNT_W'(1);
						run_q   <= run_q - srb_pkg::CNT_W'(1);
					end
				end
				default: run_q <= run_q;
			endcase
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= srb_pkg::CNT_W'(srb_pkg::DEPTH))
		else $error("held count above depth");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srb_pkg::ST_EMIT_OUT |-> count_q != '0 && run_q != '0)
		else $error("run emission from empty buffer");

	a_count_park: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srb_pkg::ST_IDLE && kind_q == srb_pkg::WAIT_COUNT)
		|-> 8'(count_q) < wlen_q)
		else $error("count read parked although enough bytes held");

	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srb_pkg::ST_EMIT_OUT && res_ready && run_q == srb_pkg::CNT_W'(1)
		|=> state_q == srb_pkg::ST_IDLE)
		else $error("sequencer did not return to idle after last byte");

endmodule

`default_nettype wire

// ----- src/serial_receive_buffer_unit.sv -----
// A receive transaction is taken in the idle state. A read passes through the memory read state, the
// emit state and the output register before its first result appears (the empty result state for a
// single read of an empty buffer); each further result repeats the read and emit states while the sink
// takes them. A terminator scan reads, then compares, each held byte examined before its run starts.
// Throughput: one request at a time; ready is low until its last result has entered the output register.
// Reset clears pointers, count, parked request and output valid; byte memory is not cleared.
// ----------------------------------------------------------------------------
// serial_receive_buffer_unit: receive byte buffer that drops the oldest byte
// Request sequencer over a byte ring plus an output register on the result
// channel.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_receive_buffer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	srb_req_if.sink   req,
	srb_rsp_if.source rsp
);

	logic          res_valid, res_ready;
	srb_pkg::res_t res;
	logic          out_valid_q;
	srb_pkg::res_t out_q;

	srb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register: takes a new result when empty or being drained
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_byte    = out_q.out_byte;
	assign rsp.last_of_run = out_q.last_of_run;
	assign rsp.empty_read  = out_q.empty_read;
	assign rsp.bytes_held  = out_q.bytes_held;

endmodule

`default_nettype wire

// ----- tb/serial_receive_buffer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// serial_receive_buffer_unit_tb: self-checking bench for the receive buffer
// Builds a list of request transactions, plays it through the request channel
// with random gaps and forced pauses, and checks every result transaction
// against a cycle-free image of the buffer kept next to the driver.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_receive_buffer_unit_tb;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TOTAL_ITEMS    = 110;
	localparam int REPORT_LIMIT   = 10;

	// Mode codes the block does not define; they must be ignored
	localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

	// Image of the buffer: ring, fill level and any parked request
	typedef struct {
		logic [7:0]          ring [srb_pkg::DEPTH];
		int unsigned         held;
		int unsigned         head;
		logic [7:0]          last_rx;
		srb_pkg::wait_kind_t wkind;
		int unsigned         wlen;
		logic [7:0]          wterm;
	} rx_buf_t;

	// One request transaction plus how it is to be played
	typedef struct {
		logic [2:0]  mode;
		logic [7:0]  data_byte;
		logic [7:0]  request_len;
		logic [7:0]  terminator;
		int unsigned gap;
		bit          drain;
		bit          hold_rx;
	} req_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic       drv_valid       = 1'b0;
	logic [2:0] drv_mode        = '0;
	logic [7:0] drv_data_byte   = '0;
	logic [7:0] drv_request_len = '0;
	logic [7:0] drv_terminator  = '0;
	logic       rx_ready        = 1'b0;

	srb_req_if req_ch ();
	srb_rsp_if rsp_ch ();

	assign req_ch.valid       = drv_valid;
	assign req_ch.mode        = drv_mode;
	assign req_ch.data_byte   = drv_data_byte;
	assign req_ch.request_len = drv_request_len;
	assign req_ch.terminator  = drv_terminator;
	assign rsp_ch.ready       = rx_ready;

	serial_receive_buffer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rx_buf_t       gen_state;
	rx_buf_t       live_state;
	req_item_t     pending_q [$];
	srb_pkg::res_t expected_q [$];
	srb_pkg::res_t scratch_q [$];
	req_item_t     cur_item;
	bit            offering      = 1'b0;
	int unsigned   gap_left      = 0;
	bit            gen_calm      = 1'b0;
	int unsigned   produced      = 0;
	int unsigned   hold_requests = 0;
	int unsigned   holds_taken   = 0;
	int unsigned   hold_left     = 0;
	int unsigned   stall_left    = 0;
	int unsigned   results_seen  = 0;
	int unsigned   fail_count    = 0;
	int unsigned   quiet_cycles  = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom);
	endfunction

	function automatic void clear_buf(ref rx_buf_t b);
		b.held    = 0;
		b.head    = 0;
		b.last_rx = '0;
		b.wkind   = srb_pkg::WAIT_NONE;
		b.wlen    = 0;
		b.wterm   = '0;
	endfunction

	// Remove up to n bytes oldest first, one result per byte
	function automatic void take_run(ref rx_buf_t b, input int unsigned n,
			ref srb_pkg::res_t q[$]);
		int unsigned   k;
		int unsigned   cnt;
		srb_pkg::res_t r;
		cnt = (n > b.held) ? b.held : n;
		for (k = 0; k < cnt; k++) begin
			r.out_byte    = b.ring[b.head];
			b.head        = (b.head + 1) % srb_pkg::DEPTH;
			b.held        = b.held - 1;
			r.last_of_run = (k + 1 == cnt);
			r.empty_read  = 1'b0;
			r.bytes_held  = 7'(b.held);
			q.push_back(r);
		end
	endfunction

	// Effect of one accepted request on the buffer, results appended to q
	function automatic void apply_request(ref rx_buf_t b, input req_item_t it,
			ref srb_pkg::res_t q[$]);
		int unsigned n;
		int unsigned i;
		bit          found;
		case (it.mode)
			srb_pkg::MODE_RECV: begin
				b.last_rx = it.data_byte;
				// full: oldest byte makes room
				if (b.held >= srb_pkg::DEPTH) begin
					b.head = (b.head + 1) % srb_pkg::DEPTH;
					b.held = srb_pkg::DEPTH - 1;
				end
				b.ring[(b.head + b.held) % srb_pkg::DEPTH] = it.data_byte;
				b.held = b.held + 1;
				if (b.wkind == srb_pkg::WAIT_COUNT && b.held >= b.wlen) begin
					b.wkind = srb_pkg::WAIT_NONE;
					take_run(b, b.wlen, q);
				end else if (b.wkind == srb_pkg::WAIT_TERM && b.last_rx == b.wterm) begin
					b.wkind = srb_pkg::WAIT_NONE;
					take_run(b, b.wlen, q);
				end
			end
			srb_pkg::MODE_READ_ONE: begin
				if (b.wkind == srb_pkg::WAIT_NONE) begin
					if (b.held == 0) begin
						q.push_back('{out_byte: srb_pkg::EMPTY_BYTE, last_of_run: 1'b1,
							empty_read: 1'b1, bytes_held: 7'(b.held)});
					end else begin
						take_run(b, 1, q);
					end
				end
			end
			srb_pkg::MODE_READ_COUNT: begin
				if (b.wkind == srb_pkg::WAIT_NONE) begin
					n = (it.request_len > srb_pkg::DEPTH) ? srb_pkg::DEPTH : it.request_len;
					if (b.held >= n) begin
						take_run(b, n, q);
					end else begin
						b.wkind = srb_pkg::WAIT_COUNT;
						b.wlen  = n;
					end
				end
			end
			srb_pkg::MODE_READ_TERM: begin
				if (b.wkind == srb_pkg::WAIT_NONE) begin
					n     = (it.request_len == 0) ? 1 : it.request_len;
					found = 1'b0;
					// run ends on the terminator or on the length limit
					for (i = 0; i < b.held && !found; i++) begin
						if (b.ring[(b.head + i) % srb_pkg::DEPTH] == it.terminator
								|| i + 1 == n) begin
							take_run(b, i + 1, q);
							found = 1'b1;
						end
					end
					if (!found) begin
						b.wkind = srb_pkg::WAIT_TERM;
						b.wlen  = n;
						b.wterm = it.terminator;
					end
				end
			end
			srb_pkg::MODE_CLEAR: begin
				if (b.wkind == srb_pkg::WAIT_NONE) begin
					b.held = 0;
					b.head = 0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Append a transaction to the play list, tracking the buffer it will meet
	function automatic void queue_item(input logic [2:0] mode, input logic [7:0] data,
			input logic [7:0] len, input logic [7:0] term, input bit drain = 1'b0,
			input bit hold_rx = 1'b0);
		req_item_t it;
		it.mode        = mode;
		it.data_byte   = data;
		it.request_len = len;
		it.terminator  = term;
		it.gap         = gen_calm ? 0 : $urandom_range(0, MAX_GAP);
		it.drain       = drain;
		it.hold_rx     = hold_rx;
		produced++;
		apply_request(gen_state, it, scratch_q);
		scratch_q.delete();
		pending_q.push_back(it);
	endfunction

	function automatic void log_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	// Request driver: one transaction at a time from the play list
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			offering = 1'b0;
			gap_left = 0;
			clear_buf(live_state);
		end else begin
			// accepted transaction: update the image and queue its results
			if (drv_valid && req_ch.ready) begin
				apply_request(live_state, cur_item, expected_q);
				if (cur_item.hold_rx) begin
					hold_requests <= hold_requests + 1;
				end
				gap_left = cur_item.gap;
				offering = 1'b0;
			end
			// next transaction after its gap; a drain item waits for all results
			if (!offering) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_q.size() != 0
						&& !(pending_q[0].drain && expected_q.size() != 0)) begin
					cur_item = pending_q.pop_front();
					offering = 1'b1;
					drv_mode        <= cur_item.mode;
					drv_data_byte   <= cur_item.data_byte;
					drv_request_len <= cur_item.request_len;
					drv_terminator  <= cur_item.terminator;
				end
			end
			drv_valid <= offering;
		end
	end

	// Result monitor: checks each transaction and paces ready
	always @(posedge clk or negedge arst_n) begin
		srb_pkg::res_t got;
		srb_pkg::res_t want;
		if (!arst_n) begin
			rx_ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (rsp_ch.valid && rx_ready) begin
				got = '{out_byte: rsp_ch.out_byte, last_of_run: rsp_ch.last_of_run,
					empty_read: rsp_ch.empty_read, bytes_held: rsp_ch.bytes_held};
				if (expected_q.size() == 0) begin
					log_failure($sformatf("result %0d not expected: byte %02h last %b empty %b held %0d",
						results_seen, got.out_byte, got.last_of_run, got.empty_read,
						got.bytes_held));
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						log_failure($sformatf({"result %0d: expected byte %02h last %b empty %b ",
							"held %0d, got byte %02h last %b empty %b held %0d"}, results_seen,
							want.out_byte, want.last_of_run, want.empty_read, want.bytes_held,
							got.out_byte, got.last_of_run, got.empty_read, got.bytes_held));
					end
				end
				results_seen++;
				// every third stretch of results runs without stalls
				stall_left = ((results_seen / 24) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
			end
			// long hold-off requested by the driver
			if (hold_requests != holds_taken) begin
				holds_taken <= hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rx_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rx_ready <= 1'b0;
			end else begin
				rx_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((drv_valid && req_ch.ready) || (rsp_ch.valid && rx_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("serial_receive_buffer_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus list, reset and end of run
	initial begin
		int unsigned pick;
		int unsigned first;
		int unsigned burst;
		bit          drain_next;
		logic [7:0]  term;
		logic [7:0]  len;
		clear_buf(gen_state);

		// Directed: empty read, count and terminator corner cases
		queue_item(srb_pkg::MODE_READ_ONE, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h00, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'hFF, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'hA5, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_READ_ONE, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_READ_COUNT, rnd_byte(), 8'd0, rnd_byte());
		queue_item(srb_pkg::MODE_READ_COUNT, rnd_byte(), 8'd2, rnd_byte());
		// count not yet held: parks, other requests are ignored meanwhile
		queue_item(srb_pkg::MODE_READ_COUNT, rnd_byte(), 8'd3, rnd_byte());
		queue_item(srb_pkg::MODE_READ_ONE, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(MODE_UNUSED_FIRST, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h31, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h32, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h33, rnd_byte(), rnd_byte());
		// zero max length on an empty buffer parks; only the terminator frees it
		queue_item(srb_pkg::MODE_READ_TERM, rnd_byte(), 8'd0, 8'h11);
		queue_item(srb_pkg::MODE_RECV, 8'h22, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h11, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_READ_TERM, rnd_byte(), 8'd255, 8'h11);
		queue_item(srb_pkg::MODE_RECV, 8'h01, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h03, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_READ_TERM, rnd_byte(), 8'd1, 8'h99);
		queue_item(srb_pkg::MODE_READ_TERM, rnd_byte(), 8'd5, 8'h03);
		queue_item(MODE_UNUSED_LAST, rnd_byte(), rnd_byte(), rnd_byte());
		// parked terminator read released with more bytes held than its limit
		queue_item(srb_pkg::MODE_READ_TERM, rnd_byte(), 8'd2, 8'h7E);
		queue_item(srb_pkg::MODE_RECV, 8'h10, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h20, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_RECV, 8'h7E, rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_READ_ONE, rnd_byte(), rnd_byte(), rnd_byte());

		// Overfill, then a saturated count read while the result side holds off
		gen_calm = 1'b1;
		repeat (srb_pkg::DEPTH + 6) begin
			queue_item(srb_pkg::MODE_RECV, rnd_byte(), rnd_byte(), rnd_byte());
		end
		queue_item(srb_pkg::MODE_READ_COUNT, rnd_byte(),
			8'($urandom_range(srb_pkg::DEPTH + 1, 255)), rnd_byte(), 1'b0, 1'b1);
		repeat (3) queue_item(srb_pkg::MODE_RECV, rnd_byte(), rnd_byte(), rnd_byte());
		queue_item(srb_pkg::MODE_READ_ONE, rnd_byte(), rnd_byte(), rnd_byte());
		gen_calm = 1'b0;
		queue_item(srb_pkg::MODE_READ_COUNT, rnd_byte(), 8'd2, rnd_byte(), 1'b1);

		// Random: mostly well-formed requests, parked requests fed until released
		while (produced < TOTAL_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				gen_calm = !gen_calm;
			end
			drain_next = ($urandom_range(0, 24) == 0);
			first = pending_q.size();
			case (gen_state.wkind)
				srb_pkg::WAIT_COUNT: begin
					if ($urandom_range(0, 7) == 0) begin
						queue_item(3'($urandom_range(srb_pkg::MODE_READ_ONE, MODE_UNUSED_LAST)),
							rnd_byte(), rnd_byte(), rnd_byte());
					end else begin
						queue_item(srb_pkg::MODE_RECV, rnd_byte(), rnd_byte(), rnd_byte());
					end
				end
				srb_pkg::WAIT_TERM: begin
					pick = $urandom_range(0, 7);
					if (pick == 0) begin
						queue_item(3'($urandom_range(srb_pkg::MODE_READ_ONE, MODE_UNUSED_LAST)),
							rnd_byte(), rnd_byte(), rnd_byte());
					end else if (pick <= 2) begin
						queue_item(srb_pkg::MODE_RECV, gen_state.wterm, rnd_byte(), rnd_byte());
					end else begin
						queue_item(srb_pkg::MODE_RECV, rnd_byte(), rnd_byte(), rnd_byte());
					end
				end
				default: begin
					pick = $urandom_range(0, 19);
					if (pick <= 5) begin
						burst = $urandom_range(1, 4);
						repeat (burst) begin
							queue_item(srb_pkg::MODE_RECV, rnd_byte(), rnd_byte(), rnd_byte());
						end
					end else if (pick <= 8) begin
						queue_item(srb_pkg::MODE_READ_ONE, rnd_byte(), rnd_byte(), rnd_byte());
					end else if (pick <= 11) begin
						len = ($urandom_range(0, 9) == 0) ? rnd_byte() : 8'($urandom_range(1, 8));
						queue_item(srb_pkg::MODE_READ_COUNT, rnd_byte(), len, rnd_byte());
					end else if (pick <= 15) begin
						// terminator mostly taken from a held byte
						if (gen_state.held != 0 && $urandom_range(0, 3) != 0) begin
							term = gen_state.ring[(gen_state.head
								+ $urandom_range(0, gen_state.held - 1)) % srb_pkg::DEPTH];
						end else begin
							term = rnd_byte();
						end
						len = ($urandom_range(0, 7) == 0) ? rnd_byte() : 8'($urandom_range(1, 12));
						queue_item(srb_pkg::MODE_READ_TERM, rnd_byte(), len, term);
					end else if (pick == 16) begin
						queue_item(srb_pkg::MODE_CLEAR, rnd_byte(), rnd_byte(), rnd_byte());
					end else if (pick == 17) begin
						queue_item(MODE_UNUSED_FIRST + 3'($urandom_range(0, 2)),
							rnd_byte(), rnd_byte(), rnd_byte());
					end else begin
						queue_item(srb_pkg::MODE_RECV, rnd_byte(), rnd_byte(), rnd_byte());
					end
				end
			endcase
			if (drain_next && pending_q.size() > first) begin
				pending_q[first].drain = 1'b1;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the list to play out, all results, then a quiet tail
		while (pending_q.size() != 0 || drv_valid) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("serial_receive_buffer_unit regression: pass");
		end else begin
			$display("serial_receive_buffer_unit regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
